// ===== rtl/ppt_pkg.sv =====
package ppt_pkg;

   localparam int COORD_BITS = 12;
   localparam int ACCUM_BITS = 16;
   localparam int CFG_BITS   = 13;
   localparam int DELTA_BITS = 10;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = CFG_BITS'(320);
   localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = CFG_BITS'(200);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_BITS'(1);

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // first packet byte: buttons in [2:0], X sign in 4, Y sign in 5
   localparam int SIGN_X_BIT = 4;
   localparam int SIGN_Y_BIT = 5;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

endpackage

// ===== rtl/ppt_axis.sv =====
module ppt_axis (
   input  logic [ppt_pkg::COORD_BITS-1:0]        pos,
   input  logic signed [ppt_pkg::DELTA_BITS-1:0] delta,
   input  logic [ppt_pkg::CFG_BITS-1:0]          bound_reg,
   input  logic signed [ppt_pkg::ACCUM_BITS-1:0] acc,
   output logic [ppt_pkg::COORD_BITS-1:0]        new_pos,
   output logic signed [ppt_pkg::ACCUM_BITS-1:0] new_acc
);
   import ppt_pkg::*;

   localparam int BW = (CFG_BITS > COORD_BITS + 1) ? CFG_BITS : COORD_BITS + 1;
   localparam int SW = COORD_BITS + 2;
   localparam int CW = (BW > SW) ? BW : SW;
   localparam int AW = ACCUM_BITS + 1;
   localparam logic [BW-1:0] TOP = BW'(1) << COORD_BITS;
   localparam logic signed [ACCUM_BITS-1:0] ACC_HI = {1'b0, {(ACCUM_BITS-1){1'b1}}};
   localparam logic signed [ACCUM_BITS-1:0] ACC_LO = {1'b1, {(ACCUM_BITS-1){1'b0}}};

   logic [BW-1:0]        reg_ext;
   logic [BW-1:0]        bound;
   logic signed [SW-1:0] moved;
   logic signed [AW-1:0] acc_sum;

   always_comb begin
      reg_ext = BW'(bound_reg);
      if (reg_ext == '0) begin
         bound = BW'(1);
      end else if (reg_ext > TOP) begin
         bound = TOP;
      end else begin
         bound = reg_ext;
      end
   end

   assign moved = $signed({2'b00, pos}) + SW'(delta);

   always_comb begin
      if (moved < 0) begin
         new_pos = '0;
      end else if (CW'($unsigned(moved)) >= CW'(bound)) begin
         new_pos = COORD_BITS'(bound - BW'(1));
      end else begin
         new_pos = COORD_BITS'(moved);
      end
   end

   assign acc_sum = AW'(acc) + AW'(delta);

   always_comb begin
      if (acc_sum[AW-1] != acc_sum[AW-2]) begin
         new_acc = acc_sum[AW-1] ? ACC_LO : ACC_HI;
      end else begin
         new_acc = acc_sum[ACCUM_BITS-1:0];
      end
   end

endmodule

// ===== rtl/pointer_packet_tracker.sv =====
// Path: a read item passes through the input register, then its result is
// captured in the result register.
// Throughput: one item per cycle; a read waits only while the result register
// is full and stalled.
// Reset: synchronous, active high; clears packet state, cursor, sums and
// buttons, and loads screen bounds 320 x 200.
module pointer_packet_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_from_aux,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ppt_pkg::COORD_BITS-1:0]        rsp_pos_x,
   output logic [ppt_pkg::COORD_BITS-1:0]        rsp_pos_y,
   output logic signed [ppt_pkg::ACCUM_BITS-1:0] rsp_delta_x_sum,
   output logic signed [ppt_pkg::ACCUM_BITS-1:0] rsp_delta_y_sum,
   output logic                                  rsp_btn_left,
   output logic                                  rsp_btn_right,
   output logic                                  rsp_btn_middle,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppt_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ppt_pkg::CFG_BITS-1:0]          csr_data
);
   import ppt_pkg::*;

   logic [CFG_BITS-1:0] width_ff, height_ff;

   logic       s1_valid_ff;
   cmd_type    s1_cmd_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_aux_ff;

   logic [7:0]                   first_ff, second_ff;
   logic [1:0]                   position_ff;
   logic [COORD_BITS-1:0]        cursor_x_ff, cursor_y_ff;
   logic signed [ACCUM_BITS-1:0] sum_dx_ff, sum_dy_ff;
   logic [2:0]                   buttons_ff;

   logic                         rsp_valid_ff;
   logic [COORD_BITS-1:0]        rsp_x_ff, rsp_y_ff;
   logic signed [ACCUM_BITS-1:0] rsp_dx_ff, rsp_dy_ff;
   logic [2:0]                   rsp_buttons_ff;

   logic s1_go, do_read, do_byte, req_take;
   logic signed [DELTA_BITS-1:0] dx, dy;
   logic signed [8:0]            dy_raw;
   logic [COORD_BITS-1:0]        cursor_x_in, cursor_y_in;
   logic signed [ACCUM_BITS-1:0] sum_dx_in, sum_dy_in;

   assign csr_ready = 1'b1;

   assign s1_go = !s1_valid_ff || (s1_cmd_ff != CMD_READ) || !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take = req_valid && !req_stall;

   assign do_read   = s1_valid_ff && s1_go && (s1_cmd_ff == CMD_READ);
   assign do_byte   = s1_valid_ff && (s1_cmd_ff == CMD_BYTE) && s1_aux_ff;

   assign dx     = DELTA_BITS'($signed({first_ff[SIGN_X_BIT], second_ff}));
   assign dy_raw = $signed({first_ff[SIGN_Y_BIT], s1_byte_ff});
   assign dy     = -DELTA_BITS'(dy_raw);

   ppt_axis u_axis_x (
      .pos       (cursor_x_ff),
      .delta     (dx),
      .bound_reg (width_ff),
      .acc       (sum_dx_ff),
      .new_pos   (cursor_x_in),
      .new_acc   (sum_dx_in)
   );

   ppt_axis u_axis_y (
      .pos       (cursor_y_ff),
      .delta     (dy),
      .bound_reg (height_ff),
      .acc       (sum_dy_ff),
      .new_pos   (cursor_y_in),
      .new_acc   (sum_dy_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= cmd_type'(req_cmd);
         s1_byte_ff <= req_data_byte;
         s1_aux_ff  <= req_from_aux;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= '0;
         second_ff   <= '0;
         position_ff <= POS_FIRST;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         sum_dx_ff   <= '0;
         sum_dy_ff   <= '0;
         buttons_ff  <= '0;
      end else if (do_read) begin
         sum_dx_ff <= '0;
         sum_dy_ff <= '0;
      end else if (do_byte) begin
         case (position_ff)
            POS_FIRST: begin
               first_ff    <= s1_byte_ff;
               position_ff <= POS_SECOND;
            end
            POS_SECOND: begin
               second_ff   <= s1_byte_ff;
               position_ff <= POS_THIRD;
            end
            default: begin
               position_ff <= POS_FIRST;
               buttons_ff  <= first_ff[2:0];
               cursor_x_ff <= cursor_x_in;
               cursor_y_ff <= cursor_y_in;
               sum_dx_ff   <= sum_dx_in;
               sum_dy_ff   <= sum_dy_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rsp_x_ff       <= cursor_x_ff;
         rsp_y_ff       <= cursor_y_ff;
         rsp_dx_ff      <= sum_dx_ff;
         rsp_dy_ff      <= sum_dy_ff;
         rsp_buttons_ff <= buttons_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_delta_x_sum = rsp_dx_ff;
   assign rsp_delta_y_sum = rsp_dy_ff;
   assign rsp_btn_left    = rsp_buttons_ff[0];
   assign rsp_btn_right   = rsp_buttons_ff[1];
   assign rsp_btn_middle  = rsp_buttons_ff[2];

endmodule
